FILE: src/servo_bus_packet_receiver_assert.svh
// Assertion macros for the servo bus packet receiver.
// Included by RTL files that check their own logic; no other dependencies.
`ifndef SERVO_BUS_PACKET_RECEIVER_ASSERT_SVH
`define SERVO_BUS_PACKET_RECEIVER_ASSERT_SVH

`ifndef SYNTH

// Checks that a condition holds in the same cycle.
`define SBPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbpr assertion failed");

// Checks that a condition holds in the cycle after.
`define SBPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbpr assertion failed");

`else

`define SBPR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SBPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/sbpr_pkg.sv
// Shared types, constants and the CRC-16 byte step for the servo bus receiver.
// No dependencies.
package sbpr_pkg;

    typedef logic [15:0] t_crc;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_CORRUPT = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef struct packed {
        logic        valid;
        logic [7:0]  payload_byte;
        logic        is_error_byte;
        logic [7:0]  device_id;
        logic [15:0] destuffed_length;
        logic        last;
        t_status     status;
    } t_result;

    localparam logic [7:0]  BYTE_FF      = 8'hFF;
    localparam logic [7:0]  BYTE_FD      = 8'hFD;
    localparam logic [7:0]  BYTE_RSRV    = 8'h00;
    localparam logic [7:0]  ID_MAX       = 8'hFC;
    localparam logic [7:0]  INSTR_STATUS = 8'h55;
    localparam logic [15:0] LEN_MIN      = 16'd4;
    localparam logic [15:0] LIMIT_RESET  = 16'd4096;
    localparam t_crc        CRC_POLY     = 16'h8005;
    localparam logic [3:0]  WIN_BYTES    = 4'd8;
    localparam logic [23:0] STUFF_MARK   = 24'hFFFFFD;

    function automatic t_crc crc_byte(input t_crc crc, input logic [7:0] b);
        t_crc c;
        begin
            c = crc ^ {b, 8'h00};
            for (int k = 0; k < 8; k++) begin
                if (c[15]) begin
                    c = {c[14:0], 1'b0} ^ CRC_POLY;
                end else begin
                    c = {c[14:0], 1'b0};
                end
            end
            return c;
        end
    endfunction

    // CRC state after the fixed header prefix FF FF FD 00.
    localparam t_crc CRC_PREFIX =
        crc_byte(crc_byte(crc_byte(crc_byte(16'h0000, BYTE_FF), BYTE_FF), BYTE_FD), BYTE_RSRV);

endpackage

FILE: src/sbpr_parser.sv
// Packet state and per-word decode: header hunt, CRC, destuffing and status.
// Depends on sbpr_pkg and servo_bus_packet_receiver_assert.svh.
`include "servo_bus_packet_receiver_assert.svh"

module sbpr_parser
    import sbpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic        i_func,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_length_limit,
    output t_result     o_res
);

    logic [63:0] r_win, n_win;
    logic [3:0]  r_fill, n_fill;
    logic        r_in_packet, n_in_packet;
    logic [15:0] r_bytes_left, n_bytes_left;
    t_crc        r_crc, n_crc;
    logic [7:0]  r_crc_low, n_crc_low;
    logic [23:0] r_hist, n_hist;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_id, n_id;
    logic        r_seen, n_seen;
    t_crc        r_crc_s1, r_crc_s2, r_crc_s3;

    logic [63:0] shifted;
    logic [3:0]  fill_inc;
    logic [15:0] hdr_len;
    logic        hdr_ok;
    logic        first;
    logic        drop;
    t_crc        crc_next;
    t_crc        crc_hdr;
    t_result     res;

    assign shifted  = {r_win[55:0], i_byte};
    assign fill_inc = (r_fill < WIN_BYTES) ? r_fill + 4'd1 : WIN_BYTES;
    assign hdr_len  = {shifted[15:8], shifted[23:16]};
    assign hdr_ok   = (shifted[63:56] == BYTE_FF) && (shifted[55:48] == BYTE_FF)
                   && (shifted[47:40] == BYTE_FD) && (shifted[39:32] == BYTE_RSRV)
                   && (shifted[31:24] <= ID_MAX) && (hdr_len >= LEN_MIN)
                   && (hdr_len <= i_length_limit) && (shifted[7:0] == INSTR_STATUS);
    assign crc_next = crc_byte(r_crc, i_byte);
    assign crc_hdr  = crc_byte(r_crc_s3, INSTR_STATUS);
    assign first    = ({1'b0, r_bytes_left} + 17'd1) == {1'b0, r_len};
    assign drop     = (i_byte == BYTE_FD) && (r_hist == STUFF_MARK);

    always_comb begin
        n_win        = r_win;
        n_fill       = r_fill;
        n_in_packet  = r_in_packet;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_crc_low    = r_crc_low;
        n_hist       = r_hist;
        n_len        = r_len;
        n_id         = r_id;
        n_seen       = r_seen;
        res          = '0;
        res.status   = ST_DATA;
        if (i_go) begin
            if (i_func) begin
                res.valid      = 1'b1;
                res.device_id  = r_in_packet ? r_id : 8'h00;
                res.last       = 1'b1;
                res.status     = r_seen ? ST_CORRUPT : ST_TIMEOUT;
                n_win          = '0;
                n_fill         = '0;
                n_in_packet    = 1'b0;
                n_bytes_left   = '0;
                n_crc          = '0;
                n_crc_low      = '0;
                n_hist         = '0;
                n_len          = '0;
                n_id           = '0;
                n_seen         = 1'b0;
            end else begin
                n_seen = 1'b1;
                if (!r_in_packet) begin
                    if (fill_inc != WIN_BYTES) begin
                        n_win  = shifted;
                        n_fill = fill_inc;
                    end else if (hdr_ok) begin
                        n_crc        = crc_hdr;
                        n_id         = shifted[31:24];
                        n_len        = hdr_len;
                        n_bytes_left = hdr_len - 16'd1;
                        n_hist       = {16'h0000, INSTR_STATUS};
                        n_win        = '0;
                        n_fill       = '0;
                        n_in_packet  = 1'b1;
                    end else begin
                        n_win  = {8'h00, shifted[55:0]};
                        n_fill = WIN_BYTES - 4'd1;
                    end
                end else if (r_bytes_left > 16'd2) begin
                    n_crc        = crc_next;
                    n_hist       = {r_hist[15:0], i_byte};
                    n_bytes_left = r_bytes_left - 16'd1;
                    if (drop) begin
                        n_len = r_len - 16'd1;
                    end else begin
                        res.valid         = 1'b1;
                        res.payload_byte  = i_byte;
                        res.is_error_byte = first;
                        res.device_id     = r_id;
                    end
                end else if (r_bytes_left == 16'd2) begin
                    n_crc_low    = i_byte;
                    n_bytes_left = 16'd1;
                end else begin
                    res.valid     = 1'b1;
                    res.device_id = r_id;
                    res.last      = 1'b1;
                    if ({i_byte, r_crc_low} == r_crc) begin
                        res.status           = ST_GOOD;
                        res.destuffed_length = r_len;
                    end else begin
                        res.status = ST_CORRUPT;
                    end
                    n_win        = '0;
                    n_fill       = '0;
                    n_in_packet  = 1'b0;
                    n_bytes_left = '0;
                    n_crc        = '0;
                    n_crc_low    = '0;
                    n_hist       = '0;
                    n_len        = '0;
                    n_id         = '0;
                    n_seen       = 1'b0;
                end
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_fill       <= '0;
            r_in_packet  <= 1'b0;
            r_bytes_left <= '0;
            r_crc        <= '0;
            r_crc_low    <= '0;
            r_hist       <= '0;
            r_len        <= '0;
            r_id         <= '0;
            r_seen       <= 1'b0;
        end else begin
            r_win        <= n_win;
            r_fill       <= n_fill;
            r_in_packet  <= n_in_packet;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_crc_low    <= n_crc_low;
            r_hist       <= n_hist;
            r_len        <= n_len;
            r_id         <= n_id;
            r_seen       <= n_seen;
        end
    end

    // Header CRC is built over the three bytes before the instruction as they arrive.
    always_ff @(posedge i_clk) begin
        if (i_go && !i_func) begin
            r_crc_s1 <= crc_byte(CRC_PREFIX, i_byte);
            r_crc_s2 <= crc_byte(r_crc_s1, i_byte);
            r_crc_s3 <= crc_byte(r_crc_s2, i_byte);
        end
    end

    `SBPR_ASSERT_NOW(a_pkt_win_empty, i_clk, i_rst_n, r_in_packet, r_fill == 4'd0)
    `SBPR_ASSERT_NOW(a_pkt_left, i_clk, i_rst_n, r_in_packet, r_bytes_left != 16'd0)
    `SBPR_ASSERT_NOW(a_len_cover, i_clk, i_rst_n, r_in_packet, r_bytes_left < r_len)
    `SBPR_ASSERT_NEXT(a_close_hunt, i_clk, i_rst_n, i_go && res.valid && res.last, !r_in_packet && r_fill == 4'd0 && !r_seen)

endmodule

FILE: src/sbpr_out_stage.sv
// Result register and output handshake for the servo bus receiver.
// Depends on sbpr_pkg.
module sbpr_out_stage
    import sbpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_adv,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_adv = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_res.valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: src/servo_bus_packet_receiver.sv
// Top level of the servo bus status packet receiver: input register and config.
// Depends on sbpr_pkg, sbpr_parser and sbpr_out_stage.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_func, i_rx_byte
//   output   out        o_valid / i_stall   o_payload_byte .. o_status
//   config   in         i_cfg_we            i_cfg_wdata (length limit)
//
// One word is accepted every cycle while o_stall is low; a word goes from the input
// register through the parser decode into the result register, which drives the outputs.
// In a packet, each body word takes one CRC byte step on the running CRC in the decode logic.
// Reset clears all packet state and sets the length limit to 4096; no clearing pass.
// o_stall rises only when the input register, and the result register both hold
// a word and i_stall is high.
module servo_bus_packet_receiver
    import sbpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_is_error_byte,
    output logic [7:0]  o_device_id,
    output logic [15:0] o_destuffed_length,
    output logic        o_last,
    output logic [1:0]  o_status
);

    logic        r_in_valid;
    logic        r_in_func;
    logic [7:0]  r_in_byte;
    logic [15:0] r_length_limit;
    logic        adv;
    logic        go;
    t_result     res;
    t_result     out_res;

    assign go      = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_length_limit <= LIMIT_RESET;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (i_cfg_we) begin
                r_length_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_func <= i_func;
            r_in_byte <= i_rx_byte;
        end
    end

    sbpr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_func         (r_in_func),
        .i_byte         (r_in_byte),
        .i_length_limit (r_length_limit),
        .o_res          (res)
    );

    sbpr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_stall (i_stall),
        .o_adv   (adv),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_payload_byte     = out_res.payload_byte;
    assign o_is_error_byte    = out_res.is_error_byte;
    assign o_device_id        = out_res.device_id;
    assign o_destuffed_length = out_res.destuffed_length;
    assign o_last             = out_res.last;
    assign o_status           = out_res.status;

endmodule

FILE: tb/tb_servo_bus_packet_receiver.sv
// Testbench for the servo bus status packet receiver: random and directed byte streams.
// Depends on sbpr_pkg and servo_bus_packet_receiver; holds its own scoreboard class.
`timescale 1ns / 100ps

import sbpr_pkg::*;

typedef struct {
    logic [7:0]  data_byte;
    logic        err_flag;
    logic [7:0]  dev_id;
    logic [15:0] dlen;
    logic        last_flag;
    t_status     status;
} t_rx_result;

function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
endfunction

class rx_scoreboard;
    t_rx_result  expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned n_good;
    int unsigned n_corrupt;
    int unsigned n_empty_timeout;
    int unsigned n_unstuffed;

    logic [15:0] limit;
    logic [63:0] window;
    logic [3:0]  fill;
    logic        in_pkt;
    logic [15:0] left;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    logic [23:0] hist;
    logic [15:0] dlen;
    logic [7:0]  pid;
    logic        seen;

    function new();
        limit = LIMIT_RESET;
        errors = 0;
        checked = 0;
        n_good = 0;
        n_corrupt = 0;
        n_empty_timeout = 0;
        n_unstuffed = 0;
        clear();
    endfunction

    function void clear();
        window = '0;
        fill = '0;
        in_pkt = 1'b0;
        left = '0;
        crc = '0;
        crc_lo = '0;
        hist = '0;
        dlen = '0;
        pid = '0;
        seen = 1'b0;
    endfunction

    function void set_limit(input logic [15:0] v);
        limit = v;
    endfunction

    function void push_result(input logic [7:0] pb, input logic err, input logic [7:0] id,
                              input logic [15:0] len, input logic lst, input t_status st);
        t_rx_result r;
        r.data_byte = pb;
        r.err_flag = err;
        r.dev_id = id;
        r.dlen = len;
        r.last_flag = lst;
        r.status = st;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_word(input logic func, input logic [7:0] b);
        logic [15:0] len;
        logic        first;
        logic        drop;
        if (func == 1'b1) begin
            if (seen) n_corrupt++;
            else n_empty_timeout++;
            push_result(8'h00, 1'b0, in_pkt ? pid : 8'h00, 16'h0000, 1'b1,
                        seen ? ST_CORRUPT : ST_TIMEOUT);
            clear();
            return;
        end
        seen = 1'b1;
        if (!in_pkt) begin
            window = {window[55:0], b};
            if (fill < WIN_BYTES) fill++;
            if (fill < WIN_BYTES) return;
            len = {window[15:8], window[23:16]};
            if (window[63:56] == BYTE_FF && window[55:48] == BYTE_FF &&
                window[47:40] == BYTE_FD && window[39:32] == BYTE_RSRV &&
                window[31:24] <= ID_MAX && len >= LEN_MIN && len <= limit &&
                window[7:0] == INSTR_STATUS) begin
                crc = '0;
                for (int k = 0; k < 8; k++) begin
                    crc = crc16_next(crc, window[63 - 8 * k -: 8]);
                end
                pid = window[31:24];
                dlen = len;
                left = len - 16'd1;
                hist = {16'h0000, INSTR_STATUS};
                window = '0;
                fill = '0;
                in_pkt = 1'b1;
            end else begin
                window[63:56] = 8'h00;
                fill = WIN_BYTES - 4'd1;
            end
            return;
        end
        if (left > 16'd2) begin
            first = ({1'b0, left} + 17'd1) == {1'b0, dlen};
            drop = (b == BYTE_FD) && (hist == STUFF_MARK);
            crc = crc16_next(crc, b);
            hist = {hist[15:0], b};
            left--;
            if (drop) begin
                dlen--;
                n_unstuffed++;
                return;
            end
            push_result(b, first, pid, 16'h0000, 1'b0, ST_DATA);
            return;
        end
        if (left == 16'd2) begin
            crc_lo = b;
            left = 16'd1;
            return;
        end
        if ({b, crc_lo} == crc) begin
            n_good++;
            push_result(8'h00, 1'b0, pid, dlen, 1'b1, ST_GOOD);
        end else begin
            n_corrupt++;
            push_result(8'h00, 1'b0, pid, 16'h0000, 1'b1, ST_CORRUPT);
        end
        clear();
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    function void check_result(input t_rx_result got);
        t_rx_result want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual byte 0x%0h status %0d",
                     $time, got.data_byte, got.status);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare_field("payload_byte", want.data_byte, got.data_byte);
        compare_field("is_error_byte", want.err_flag, got.err_flag);
        compare_field("device_id", want.dev_id, got.dev_id);
        compare_field("destuffed_length", want.dlen, got.dlen);
        compare_field("last", want.last_flag, got.last_flag);
        compare_field("status", want.status, got.status);
    endfunction
endclass

module tb_servo_bus_packet_receiver;

    localparam logic        FUNC_BYTE    = 1'b0;
    localparam logic        FUNC_TIMEOUT = 1'b1;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 8;

    typedef enum {
        EV_GOOD,
        EV_BAD_CRC,
        EV_CUT,
        EV_NOISE,
        EV_TIMEOUT,
        EV_BAD_HDR
    } t_event;

    typedef enum {
        HB_ID,
        HB_RSRV,
        HB_SHORT_LEN,
        HB_LONG_LEN,
        HB_INSTR,
        HB_MARK
    } t_hdr_break;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        i_func;
    logic [7:0]  i_rx_byte;
    logic        o_stall;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_payload_byte;
    logic        o_is_error_byte;
    logic [7:0]  o_device_id;
    logic [15:0] o_destuffed_length;
    logic        o_last;
    logic [1:0]  o_status;

    rx_scoreboard sb;
    int unsigned  words_sent;
    int unsigned  cycle_count;
    int unsigned  limits_used;
    int           cur_limit;
    logic         calm_in;
    logic         calm_out;

    servo_bus_packet_receiver dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .i_func             (i_func),
        .i_rx_byte          (i_rx_byte),
        .o_stall            (o_stall),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_payload_byte     (o_payload_byte),
        .o_is_error_byte    (o_is_error_byte),
        .o_device_id        (o_device_id),
        .o_destuffed_length (o_destuffed_length),
        .o_last             (o_last),
        .o_status           (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** servo_bus_packet_receiver: FAILED **");
        $finish;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return BYTE_FF;
            1: return BYTE_FD;
            2: return BYTE_RSRV;
            3: return INSTR_STATUS;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_stuffed(ref logic [7:0] q[$], input logic [7:0] x);
        q.insert(q.size(), x);
        if (q.size() >= 3 && q[q.size() - 3] == BYTE_FF && q[q.size() - 2] == BYTE_FF &&
            q[q.size() - 1] == BYTE_FD) begin
            q.insert(q.size(), BYTE_FD);
        end
    endfunction

    task automatic send_word(input logic f, input logic [7:0] b);
        int gap;
        i_valid <= 1'b1;
        i_func <= f;
        i_rx_byte <= b;
        do begin
            @(posedge i_clk);
        end while (!(i_valid === 1'b1 && o_stall === 1'b0));
        sb.note_word(f, b);
        words_sent++;
        gap = calm_in ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_rx_byte <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_packet(input logic [7:0] id, input logic [7:0] err,
                               input int n_params, input t_event mode);
        logic [7:0]  body[$];
        logic [7:0]  frame[$];
        logic [15:0] len;
        logic [15:0] crc;
        int          idx;
        int          cut;
        body.insert(body.size(), INSTR_STATUS);
        push_stuffed(body, err);
        for (int k = 0; k < n_params; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_stuffed(body, BYTE_FF);
                push_stuffed(body, BYTE_FF);
                push_stuffed(body, BYTE_FD);
            end else begin
                push_stuffed(body, pick_byte());
            end
        end
        len = 16'(body.size() + 2);
        frame = '{BYTE_FF, BYTE_FF, BYTE_FD, BYTE_RSRV, id, len[7:0], len[15:8]};
        foreach (body[k]) frame.insert(frame.size(), body[k]);
        crc = '0;
        foreach (frame[k]) crc = crc16_next(crc, frame[k]);
        frame.insert(frame.size(), crc[7:0]);
        frame.insert(frame.size(), crc[15:8]);
        if (mode == EV_BAD_CRC) begin
            idx = frame.size() - 1 - $urandom_range(0, 1);
            frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (mode == EV_CUT) begin
            cut = $urandom_range(1, frame.size() - 1);
            for (int k = 0; k < cut; k++) send_word(FUNC_BYTE, frame[k]);
            send_word(FUNC_TIMEOUT, 8'($urandom));
        end else begin
            foreach (frame[k]) send_word(FUNC_BYTE, frame[k]);
        end
    endtask

    task automatic send_bad_header(input t_hdr_break kind);
        logic [7:0]  hdr[8];
        logic [15:0] len;
        len = 16'($urandom_range(4, 30));
        hdr = '{BYTE_FF, BYTE_FF, BYTE_FD, BYTE_RSRV, 8'($urandom_range(0, ID_MAX)),
                8'h00, 8'h00, INSTR_STATUS};
        case (kind)
            HB_ID: hdr[4] = 8'($urandom_range(ID_MAX + 1, 255));
            HB_RSRV: hdr[3] = 8'($urandom_range(1, 255));
            HB_SHORT_LEN: len = 16'($urandom_range(0, LEN_MIN - 1));
            HB_LONG_LEN: begin
                if (cur_limit < 65535) len = 16'($urandom_range(cur_limit + 1, 65535));
                else hdr[4] = BYTE_FF;
            end
            HB_INSTR: hdr[7] = INSTR_STATUS ^ 8'($urandom_range(1, 255));
            default: hdr[2] = BYTE_FD ^ 8'($urandom_range(1, 255));
        endcase
        hdr[5] = len[7:0];
        hdr[6] = len[15:8];
        foreach (hdr[k]) send_word(FUNC_BYTE, hdr[k]);
    endtask

    task automatic write_limit(input int v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 16'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(16'(v));
        cur_limit = v;
        limits_used++;
    endtask

    task automatic end_phase();
        send_word(FUNC_TIMEOUT, 8'($urandom));
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n_words);
        int unsigned start;
        int          r;
        int          n_params;
        logic [7:0]  id;
        start = words_sent;
        while (words_sent - start < n_words) begin
            if ($urandom_range(0, 7) == 0) calm_in = ~calm_in;
            if ($urandom_range(0, 7) == 0) calm_out = ~calm_out;
            r = $urandom_range(0, 99);
            n_params = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(0, 10);
            if (cur_limit <= 8) n_params = $urandom_range(0, 2);
            case ($urandom_range(0, 4))
                0: id = 8'h00;
                1: id = ID_MAX;
                default: id = 8'($urandom_range(0, ID_MAX));
            endcase
            if (r < 55) begin
                send_packet(id, pick_byte(), n_params, EV_GOOD);
            end else if (r < 65) begin
                send_packet(id, pick_byte(), n_params, EV_BAD_CRC);
            end else if (r < 73) begin
                send_packet(id, pick_byte(), n_params, EV_CUT);
            end else if (r < 82) begin
                repeat ($urandom_range(1, 6)) send_word(FUNC_BYTE, pick_byte());
            end else if (r < 87) begin
                send_word(FUNC_TIMEOUT, 8'($urandom));
            end else begin
                send_bad_header(t_hdr_break'($urandom_range(0, 5)));
            end
        end
    endtask

    initial begin : result_monitor
        int         stall_left;
        t_rx_result got;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall == 1'b0) begin
                got.data_byte = o_payload_byte;
                got.err_flag = o_is_error_byte;
                got.dev_id = o_device_id;
                got.dlen = o_destuffed_length;
                got.last_flag = o_last;
                got.status = t_status'(o_status);
                sb.check_result(got);
                stall_left = calm_out ? 0 : $urandom_range(0, 8);
                if (stall_left > 0) i_stall <= 1'b1;
            end else if (i_stall == 1'b1) begin
                stall_left--;
                if (stall_left <= 0) i_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int phase_limit[7];
        int phase_words[7];
        sb = new();
        words_sent = 0;
        limits_used = 0;
        cur_limit = LIMIT_RESET;
        calm_in = 1'b0;
        calm_out = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_BYTE;
        i_rx_byte = 8'h00;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 16'h0000;
        i_stall = 1'b0;
        phase_limit = '{65535, 4, 3, 0, 20, 0, 4096};
        phase_words = '{220, 110, 50, 40, 170, 170, 160};
        phase_limit[5] = $urandom_range(4, 200);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Timeout with nothing received, the shortest packet, a cut stuffed packet.
        send_word(FUNC_TIMEOUT, 8'h00);
        send_packet(8'h00, 8'h00, 0, EV_GOOD);
        send_word(FUNC_BYTE, BYTE_FF);
        send_word(FUNC_BYTE, BYTE_FF);
        send_word(FUNC_BYTE, BYTE_FD);
        send_word(FUNC_BYTE, BYTE_RSRV);
        send_word(FUNC_BYTE, ID_MAX);
        send_word(FUNC_BYTE, 8'd9);
        send_word(FUNC_BYTE, 8'd0);
        send_word(FUNC_BYTE, INSTR_STATUS);
        send_word(FUNC_BYTE, BYTE_FF);
        send_word(FUNC_BYTE, BYTE_FF);
        send_word(FUNC_BYTE, BYTE_FD);
        send_word(FUNC_BYTE, BYTE_FD);
        send_word(FUNC_BYTE, 8'h80);
        send_word(FUNC_BYTE, 8'($urandom));
        send_word(FUNC_BYTE, 8'($urandom));
        end_phase();

        for (int p = 0; p < 7; p++) begin
            write_limit(phase_limit[p]);
            run_phase(phase_words[p]);
            end_phase();
        end

        $display("Sent %0d words under %0d length limit settings; checked %0d results.",
                 words_sent, limits_used, sb.checked);
        $display("Good packets %0d, corrupt or cut %0d, empty timeouts %0d, stuffing removed %0d.",
                 sb.n_good, sb.n_corrupt, sb.n_empty_timeout, sb.n_unstuffed);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** servo_bus_packet_receiver: PASSED **");
        end else begin
            $display("** servo_bus_packet_receiver: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/sbpr_pkg.sv
src/sbpr_parser.sv
src/sbpr_out_stage.sv
src/servo_bus_packet_receiver.sv
tb/tb_servo_bus_packet_receiver.sv
